FILE: rtl/wsil_pkg.sv
// ----------------------------------------------------------------------------
// wsil_pkg - word set insert/lookup shared definitions
// Sizes, transaction payload types, result codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wsil_pkg;

    localparam int MAX_ENTRIES = 12;
    localparam int WORD_CHARS  = 20;
    localparam int WORD_BITS   = WORD_CHARS * 8;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W       = $clog2(WORD_CHARS + 1);

    typedef enum logic [2:0] {
        RC_ADDED     = 3'd0,
        RC_PRESENT   = 3'd1,
        RC_FULL      = 3'd2,
        RC_FOUND     = 3'd3,
        RC_NOT_FOUND = 3'd4,
        RC_TOO_LONG  = 3'd5
    } t_result_code;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH
    } t_state;

    typedef struct packed {
        logic       operation;
        logic [7:0] character;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [2:0] result_code;
        logic [3:0] entry_index;
        logic [3:0] entry_count;
    } t_out_item;

    typedef struct packed {
        logic         append;   // take the offered character
        logic         rd_en;    // read one stored entry
        logic         rd_next;  // read entry after current, else entry 0
        logic         wr_en;    // store buffer at next free entry
        logic         emit;     // post result and clear the word
        t_result_code code;
    } t_dp_cmd;

    typedef struct packed {
        logic overlong;
        logic op_lookup;
        logic full;
        logic empty;
        logic match;  // entry read last cycle equals the buffer
        logic more;   // another stored entry lies after the current one
    } t_dp_status;

endpackage

FILE: rtl/wsil_datapath.sv
// ----------------------------------------------------------------------------
// wsil_datapath - word assembly, entry store and compare
// Builds the word one byte at a time, holds the stored entries in a memory
// with registered read, compares one entry a cycle and forms the result.
// ----------------------------------------------------------------------------
module wsil_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wsil_pkg::t_in_item   i_item,
    input  wsil_pkg::t_dp_cmd    i_cmd,
    output wsil_pkg::t_dp_status o_status,
    output wsil_pkg::t_out_item  o_item,
    output logic                 o_strobe
);

    logic [wsil_pkg::WORD_BITS-1:0] mem [wsil_pkg::MAX_ENTRIES];

    logic [wsil_pkg::WORD_BITS-1:0] r_buf,   n_buf;
    logic [wsil_pkg::POS_W-1:0]     r_pos,   n_pos;
    logic                           r_over,  n_over;
    logic                           r_op;
    logic [wsil_pkg::CNT_W-1:0]     r_count, n_count;
    logic [wsil_pkg::IDX_W-1:0]     r_idx;
    logic [wsil_pkg::WORD_BITS-1:0] r_rdata;
    wsil_pkg::t_out_item            r_out,   n_out;
    logic                           r_strobe;

    logic [wsil_pkg::IDX_W-1:0]     rd_addr;
    logic [wsil_pkg::CNT_W-1:0]     idx_plus;
    logic [31:0]                    idx_wide;
    logic [31:0]                    cnt_wide;
    logic [31:0]                    cnt_after;
    logic [3:0]                     out_index;

    assign idx_plus = wsil_pkg::CNT_W'(r_idx) + 1'b1;
    assign rd_addr  = i_cmd.rd_next ? idx_plus[wsil_pkg::IDX_W-1:0] : '0;

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[r_count[wsil_pkg::IDX_W-1:0]] <= r_buf;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
            r_idx   <= rd_addr;
        end
    end

    always_comb begin
        n_buf  = r_buf;
        n_pos  = r_pos;
        n_over = r_over;
        if (i_cmd.emit) begin
            n_buf  = '0;
            n_pos  = '0;
            n_over = 1'b0;
        end else if (i_cmd.append) begin
            if (r_pos < wsil_pkg::POS_W'(wsil_pkg::WORD_CHARS)) begin
                for (int k = 0; k < wsil_pkg::WORD_CHARS; k++) begin
                    if (r_pos == wsil_pkg::POS_W'(k)) begin
                        n_buf[k*8 +: 8] = i_item.character;
                    end
                end
                n_pos = r_pos + 1'b1;
            end else begin
                n_over = 1'b1;
            end
        end
    end

    assign n_count = i_cmd.wr_en ? r_count + 1'b1 : r_count;

    assign idx_wide  = 32'(r_idx);
    assign cnt_wide  = 32'(r_count);
    assign cnt_after = 32'(n_count);

    always_comb begin
        case (i_cmd.code)
            wsil_pkg::RC_FOUND, wsil_pkg::RC_PRESENT: out_index = idx_wide[3:0];
            wsil_pkg::RC_ADDED:                       out_index = cnt_wide[3:0];
            default:                                  out_index = '0;
        endcase
        n_out.result_code = i_cmd.code;
        n_out.entry_index = out_index;
        n_out.entry_count = cnt_after[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf    <= '0;
            r_pos    <= '0;
            r_over   <= 1'b0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_buf    <= n_buf;
            r_pos    <= n_pos;
            r_over   <= n_over;
            r_count  <= n_count;
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_op <= i_item.operation;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_status.overlong  = r_over;
    assign o_status.op_lookup = r_op;
    assign o_status.full      = r_count >= wsil_pkg::CNT_W'(wsil_pkg::MAX_ENTRIES);
    assign o_status.empty     = r_count == '0;
    assign o_status.match     = r_rdata == r_buf;
    assign o_status.more      = idx_plus < r_count;

    assign o_item   = r_out;
    assign o_strobe = r_strobe;

endmodule

FILE: rtl/wsil_ctrl.sv
// ----------------------------------------------------------------------------
// wsil_ctrl - word set insert/lookup controller
// Takes characters while idle, then on a word end walks the stored entries
// and decides the result code.
// ----------------------------------------------------------------------------
module wsil_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 i_last,
    input  wsil_pkg::t_dp_status i_status,
    output wsil_pkg::t_dp_cmd    o_cmd,
    output logic                 busy
);

    wsil_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsil_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.append  = 1'b0;
        o_cmd.rd_en   = 1'b0;
        o_cmd.rd_next = 1'b0;
        o_cmd.wr_en   = 1'b0;
        o_cmd.emit    = 1'b0;
        o_cmd.code    = wsil_pkg::RC_ADDED;
        busy          = 1'b1;
        unique case (r_state)
            wsil_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.append = 1'b1;
                    if (i_last) begin
                        n_state = wsil_pkg::S_CHECK;
                    end
                end
            end
            wsil_pkg::S_CHECK: begin
                if (i_status.overlong) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = wsil_pkg::RC_TOO_LONG;
                    n_state    = wsil_pkg::S_IDLE;
                end else if (!i_status.op_lookup && i_status.full) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = wsil_pkg::RC_FULL;
                    n_state    = wsil_pkg::S_IDLE;
                end else if (i_status.empty) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.wr_en = !i_status.op_lookup;
                    o_cmd.code  = i_status.op_lookup ? wsil_pkg::RC_NOT_FOUND
                                                     : wsil_pkg::RC_ADDED;
                    n_state     = wsil_pkg::S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = wsil_pkg::S_SEARCH;
                end
            end
            wsil_pkg::S_SEARCH: begin
                if (i_status.match) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = i_status.op_lookup ? wsil_pkg::RC_FOUND
                                                    : wsil_pkg::RC_PRESENT;
                    n_state    = wsil_pkg::S_IDLE;
                end else if (i_status.more) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                end else begin
                    // no entry matched: lookup misses, insert stores
                    o_cmd.emit  = 1'b1;
                    o_cmd.wr_en = !i_status.op_lookup;
                    o_cmd.code  = i_status.op_lookup ? wsil_pkg::RC_NOT_FOUND
                                                     : wsil_pkg::RC_ADDED;
                    n_state     = wsil_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wsil_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/word_set_insert_lookup_unit.sv
// ----------------------------------------------------------------------------
// word_set_insert_lookup_unit - word set with insert and lookup
// Channel   Direction  Handshake               Payload
// item      in         start & !busy           i_item  (operation, character, last_char)
// result    out        o_strobe, one cycle     o_item  (result_code, entry_index, entry_count)
//
// Non-final characters are taken one per cycle while idle. A word end holds
// busy while the word is checked and the stored entries compared, one per
// cycle through the single read port of the entry memory; the result
// strobes in the first cycle with busy low. Reset empties the set and the
// word being built; no clearing pass is needed. The receiver cannot stall.
// ----------------------------------------------------------------------------
module word_set_insert_lookup_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  wsil_pkg::t_in_item  i_item,
    output wsil_pkg::t_out_item o_item,
    output logic                o_strobe
);

    wsil_pkg::t_dp_cmd    cmd;
    wsil_pkg::t_dp_status status;

    wsil_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_last   (i_item.last_char),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    wsil_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_item   (o_item),
        .o_strobe (o_strobe)
    );

endmodule

FILE: rtl/wsil_checker.sv
// ----------------------------------------------------------------------------
// wsil_checker - port level checks for the word set unit
// Watches transactions at the top level ports; bound to the top level.
// ----------------------------------------------------------------------------
module wsil_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input wsil_pkg::t_in_item  i_item,
    input wsil_pkg::t_out_item o_item,
    input logic                o_strobe
);

    // a word end accepted while idle always raises busy
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.last_char |=> busy)
        else $error("word end not followed by busy");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results on consecutive cycles");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while still busy");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_item.result_code <= wsil_pkg::RC_TOO_LONG) &&
                     (o_item.entry_count <= 4'(wsil_pkg::MAX_ENTRIES)))
        else $error("result code or count out of range");

    // a new word lands at the last occupied index
    a_added_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_item.result_code == wsil_pkg::RC_ADDED) |->
            o_item.entry_index == 4'(o_item.entry_count - 4'd1))
        else $error("added index does not match count");

endmodule

bind word_set_insert_lookup_unit wsil_checker u_wsil_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_item   (o_item),
    .o_strobe (o_strobe)
);
